// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UNHS_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UNHS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/unhs_pkg.sv
// Shared types, constants and state codes of the UCB1 next hop selector.
`default_nettype none

package unhs_pkg;

  localparam int NODES_DEF = 16;
  localparam int CAND_CAP  = 16;
  localparam int CIDX_W    = 4;
  localparam int CNT_W     = 32;
  localparam int TOT_W     = CNT_W + CIDX_W;
  localparam int K_W       = 6;
  localparam int LN_W      = K_W + 16;
  localparam int MEAN_W    = 17;
  localparam int DIVD_W    = 48;
  localparam int SQ_IN_W   = 40;
  localparam int SQ_W      = 20;
  localparam int SCORE_W   = 24;
  localparam int GAIN_W    = 16;

  localparam logic [7:0]         HOP_NONE   = 8'hFF;
  localparam logic [15:0]        LN2_Q16    = 16'd45426;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 24'hFF_FFFF;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd5793;
  localparam logic [CNT_W-1:0]   CNT_MAX    = 32'hFFFF_FFFF;

  localparam logic KIND_SELECT   = 1'b0;
  localparam logic KIND_SNAPSHOT = 1'b1;

  typedef enum logic [1:0] {
    FN_RECORD = 2'd0,
    FN_CAND   = 2'd1,
    FN_QUERY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    OP_RECORD,
    OP_CAND,
    OP_QUERY
  } op_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] destination;
    logic [7:0] next_hop;
    logic       success;
    logic       healthy;
    logic [7:0] exclude_hop;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        chosen_hop;
    logic [CNT_W-1:0]  attempts;
    logic [CNT_W-1:0]  successes;
    logic [CNT_W-1:0]  failures;
    logic [MEAN_W-1:0] mean_reward;
  } out_item_t;

  // Command handed from the front end to the engine through the queue.
  typedef struct packed {
    op_t        op;
    logic       ids_ok;
    logic [7:0] dest;
    logic [7:0] hop;
    logic       success;
    logic       healthy;
    logic [7:0] excl;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] fail;
    logic [CNT_W-1:0] succ;
    logic [CNT_W-1:0] att;
  } arm_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REC_RD,
    ST_REC_WR,
    ST_QRY_RD,
    ST_QRY_DIV,
    ST_QRY_WAIT,
    ST_SEL_SCAN,
    ST_SEL_FILT,
    ST_SEL_ARD,
    ST_SEL_ACHK,
    ST_LOG_NORM,
    ST_LOG_SQ,
    ST_LOG_MUL,
    ST_SC_RD,
    ST_SC_DIVR,
    ST_SC_WAITR,
    ST_SC_WAITQ,
    ST_SC_BONUS,
    ST_SC_WAITM,
    ST_SC_CMP,
    ST_EMIT
  } bk_state_t;

endpackage

`default_nettype wire

// File: rtl/unhs_front.sv
// Front end: accepts items, drops those with no effect, queues the rest.
`default_nettype none

module unhs_front #(
  parameter int NODES = unhs_pkg::NODES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  unhs_pkg::in_item_t  in_data,
  input  wire                 clear_busy,
  output logic                q_valid,
  input  wire                 q_pop,
  output unhs_pkg::cmd_t      q_cmd
);

  unhs_pkg::cmd_t cmd_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     fill_r;

  unhs_pkg::cmd_t cls;
  logic           dest_ok;
  logic           hop_ok;
  logic           keep;
  logic           push;
  logic           pop;

  always_comb begin
    dest_ok = int'(in_data.destination) < NODES;
    hop_ok  = int'(in_data.next_hop) < NODES;
    cls.ids_ok  = dest_ok && hop_ok;
    cls.dest    = in_data.destination;
    cls.hop     = in_data.next_hop;
    cls.success = in_data.success;
    cls.healthy = in_data.healthy;
    cls.excl    = in_data.exclude_hop;
    cls.last    = in_data.last;
    case (in_data.func)
      unhs_pkg::FN_RECORD: begin
        cls.op = unhs_pkg::OP_RECORD;
        keep   = dest_ok && hop_ok;
      end
      unhs_pkg::FN_CAND: begin
        cls.op = unhs_pkg::OP_CAND;
        keep   = 1'b1;
      end
      unhs_pkg::FN_QUERY: begin
        cls.op = unhs_pkg::OP_QUERY;
        keep   = 1'b1;
      end
      default: begin
        cls.op = unhs_pkg::OP_QUERY;
        keep   = 1'b0;
      end
    endcase
  end

  assign in_ready = !clear_busy && (fill_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = fill_r != 2'd0;
  assign pop      = q_pop && q_valid;
  assign q_cmd    = cmd_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/unhs_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module unhs_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [unhs_pkg::DIVD_W-1:0]   dividend,
  input  wire [unhs_pkg::CNT_W-1:0]    divisor,
  output logic                         done,
  output logic [unhs_pkg::DIVD_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(unhs_pkg::DIVD_W);

  logic                        busy_r;
  logic                        done_r;
  logic [STEP_W-1:0]           step_r;
  logic [unhs_pkg::DIVD_W-1:0] num_r;
  logic [unhs_pkg::CNT_W-1:0]  rem_r;
  logic [unhs_pkg::CNT_W-1:0]  den_r;

  logic [unhs_pkg::CNT_W:0]    rem_sh;
  logic                        qbit;
  logic [unhs_pkg::CNT_W:0]    rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, num_r[unhs_pkg::DIVD_W-1]};
    qbit    = rem_sh >= {1'b0, den_r};
    rem_nxt = qbit ? rem_sh - {1'b0, den_r} : rem_sh;
  end

  assign done     = done_r;
  assign quotient = num_r;

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[unhs_pkg::DIVD_W-2:0], qbit};
      rem_r <= rem_nxt[unhs_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(unhs_pkg::DIVD_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/unhs_sqrt.sv
// Integer square root, one root bit per cycle.
`default_nettype none

module unhs_sqrt (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [unhs_pkg::SQ_IN_W-1:0]  radicand,
  output logic                         done,
  output logic [unhs_pkg::SQ_W-1:0]    root
);

  localparam int STEP_W = $clog2(unhs_pkg::SQ_W);
  localparam int REM_W  = unhs_pkg::SQ_W + 2;

  logic                         busy_r;
  logic                         done_r;
  logic [STEP_W-1:0]            step_r;
  logic [unhs_pkg::SQ_IN_W-1:0] val_r;
  logic [REM_W-1:0]             rem_r;
  logic [unhs_pkg::SQ_W-1:0]    root_r;

  logic [REM_W+1:0]             rem_sh;
  logic [REM_W+1:0]             trial;
  logic                         ge;
  logic [REM_W+1:0]             rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, val_r[unhs_pkg::SQ_IN_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    ge      = rem_sh >= trial;
    rem_nxt = ge ? rem_sh - trial : rem_sh;
  end

  assign done = done_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[unhs_pkg::SQ_IN_W-3:0], 2'b00};
      rem_r  <= rem_nxt[REM_W-1:0];
      root_r <= {root_r[unhs_pkg::SQ_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(unhs_pkg::SQ_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/unhs_back.sv
// Engine: counter memory, candidate store, UCB1 scoring sequencer, result register.
`default_nettype none

module unhs_back #(
  parameter int NODES = unhs_pkg::NODES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [unhs_pkg::GAIN_W-1:0]   gain,
  input  wire                          q_valid,
  output logic                         q_pop,
  input  unhs_pkg::cmd_t               q_cmd,
  output logic                         clear_busy,
  output logic                         out_valid,
  input  wire                          out_ready,
  output unhs_pkg::out_item_t          out_data
);

  localparam int ENTRIES = NODES * NODES;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int ARM_W   = 3 * unhs_pkg::CNT_W;
  localparam int J_W     = unhs_pkg::CIDX_W + 1;
  localparam logic [J_W-1:0] J_END = J_W'(unhs_pkg::CAND_CAP);
  localparam int SQ_CNT_W = 4;

  function automatic logic [ADDR_W-1:0] arm_addr(input logic [7:0] d, input logic [7:0] h);
    arm_addr = ADDR_W'(int'(d) * NODES + int'(h));
  endfunction

  function automatic logic [unhs_pkg::CNT_W-1:0] sat_inc(input logic [unhs_pkg::CNT_W-1:0] c);
    sat_inc = (c == unhs_pkg::CNT_MAX) ? c : c + 1'b1;
  endfunction

  // counter memory
  logic [ARM_W-1:0]   mem [ENTRIES];
  unhs_pkg::arm_t     mem_rdata_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  unhs_pkg::arm_t     mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  unhs_pkg::bk_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  clr_r;
  unhs_pkg::cmd_t     cur_r;

  logic [7:0]                  cand_hop_r [unhs_pkg::CAND_CAP];
  logic [unhs_pkg::CAND_CAP-1:0] cand_hlth_r;
  logic [J_W-1:0]              cand_cnt_r;
  logic [7:0]                  run_dest_r;
  logic [7:0]                  run_excl_r;

  logic [J_W-1:0]              j_r;
  logic [unhs_pkg::CAND_CAP-1:0] elig_r;
  logic [J_W-1:0]              ne_r;
  logic                        anyh_r;
  logic [unhs_pkg::TOT_W-1:0]  total_r;
  logic [unhs_pkg::TOT_W-1:0]  norm_r;
  logic [unhs_pkg::K_W-1:0]    k_r;
  logic [30:0]                 m_r;
  logic [15:0]                 frac_r;
  logic [SQ_CNT_W-1:0]         sq_i_r;
  logic [unhs_pkg::LN_W-1:0]   lnv_r;
  logic [unhs_pkg::CNT_W-1:0]  att_r;
  logic [unhs_pkg::CNT_W-1:0]  suc_r;
  logic [unhs_pkg::SQ_W-1:0]   root_r;
  logic [unhs_pkg::SCORE_W-1:0] bonus_r;
  logic [unhs_pkg::MEAN_W-1:0] mean_r;
  logic [7:0]                  best_hop_r;
  logic [unhs_pkg::SCORE_W-1:0] best_score_r;

  unhs_pkg::out_item_t res_r;
  unhs_pkg::out_item_t out_data_r;
  logic                out_valid_r;

  // arithmetic units; the divider is shared by snapshots and scoring
  logic                          div_start;
  logic [unhs_pkg::DIVD_W-1:0]   div_dvd;
  logic [unhs_pkg::CNT_W-1:0]    div_dvs;
  logic                          div_done;
  logic [unhs_pkg::DIVD_W-1:0]   div_q;
  logic                          sq_start;
  logic                          sq_done;
  logic [unhs_pkg::SQ_W-1:0]     sq_root;

  unhs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  unhs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({2'b00, div_q[37:0]}),
    .done     (sq_done),
    .root     (sq_root)
  );

  // candidate at the pass index
  logic [unhs_pkg::CIDX_W-1:0] jx;
  logic [7:0]                  j_hop;
  logic                        j_elig;
  logic                        scan_ok;
  logic                        dest_bad;
  logic                        emit_free;
  logic [61:0]                 sq_prod;
  logic [31:0]                 sq_val;
  logic [37:0]                 ln_prod;
  logic [35:0]                 bonus_prod;
  logic [unhs_pkg::SCORE_W:0]  score_sum;
  logic [unhs_pkg::SCORE_W-1:0] score;
  logic                        better;

  always_comb begin
    jx        = j_r[unhs_pkg::CIDX_W-1:0];
    j_hop     = cand_hop_r[jx];
    j_elig    = elig_r[jx];
    dest_bad  = int'(run_dest_r) >= NODES;
    scan_ok   = (j_hop != run_excl_r) && (int'(j_hop) < NODES) && (int'(ne_r) < NODES);
    emit_free = !out_valid_r || out_ready;
    sq_prod   = m_r * m_r;
    sq_val    = sq_prod[61:30];
    ln_prod   = {k_r, frac_r} * unhs_pkg::LN2_Q16;
    bonus_prod = gain * root_r;
    score_sum = {1'b0, bonus_r} + (unhs_pkg::SCORE_W + 1)'(mean_r);
    score     = score_sum[unhs_pkg::SCORE_W] ? unhs_pkg::SCORE_MAX
                                             : score_sum[unhs_pkg::SCORE_W-1:0];
    better    = (best_hop_r == unhs_pkg::HOP_NONE) || (score > best_score_r) ||
                ((score == best_score_r) && (j_hop < best_hop_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      unhs_pkg::ST_CLEAR: begin
        if (clr_r == ADDR_W'(ENTRIES - 1)) state_nxt = unhs_pkg::ST_IDLE;
      end
      unhs_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            unhs_pkg::OP_RECORD: state_nxt = unhs_pkg::ST_REC_RD;
            unhs_pkg::OP_CAND:
              state_nxt = q_cmd.last ? unhs_pkg::ST_SEL_SCAN : unhs_pkg::ST_IDLE;
            unhs_pkg::OP_QUERY:
              state_nxt = q_cmd.ids_ok ? unhs_pkg::ST_QRY_RD : unhs_pkg::ST_EMIT;
            default: state_nxt = unhs_pkg::ST_IDLE;
          endcase
        end
      end
      unhs_pkg::ST_REC_RD:  state_nxt = unhs_pkg::ST_REC_WR;
      unhs_pkg::ST_REC_WR:  state_nxt = unhs_pkg::ST_IDLE;
      unhs_pkg::ST_QRY_RD:  state_nxt = unhs_pkg::ST_QRY_DIV;
      unhs_pkg::ST_QRY_DIV: begin
        state_nxt = (mem_rdata_r.att == '0) ? unhs_pkg::ST_EMIT : unhs_pkg::ST_QRY_WAIT;
      end
      unhs_pkg::ST_QRY_WAIT: if (div_done) state_nxt = unhs_pkg::ST_EMIT;
      unhs_pkg::ST_SEL_SCAN: begin
        if (dest_bad) state_nxt = unhs_pkg::ST_EMIT;
        else if (j_r == cand_cnt_r) state_nxt = unhs_pkg::ST_SEL_FILT;
      end
      unhs_pkg::ST_SEL_FILT: begin
        state_nxt = (ne_r == '0) ? unhs_pkg::ST_EMIT : unhs_pkg::ST_SEL_ARD;
      end
      unhs_pkg::ST_SEL_ARD: begin
        if (j_r == J_END) state_nxt = unhs_pkg::ST_LOG_NORM;
        else if (j_elig) state_nxt = unhs_pkg::ST_SEL_ACHK;
      end
      unhs_pkg::ST_SEL_ACHK: begin
        state_nxt = (mem_rdata_r.att == '0) ? unhs_pkg::ST_EMIT : unhs_pkg::ST_SEL_ARD;
      end
      unhs_pkg::ST_LOG_NORM: begin
        if (norm_r[unhs_pkg::TOT_W-1]) state_nxt = unhs_pkg::ST_LOG_SQ;
      end
      unhs_pkg::ST_LOG_SQ: begin
        if (sq_i_r == '1) state_nxt = unhs_pkg::ST_LOG_MUL;
      end
      unhs_pkg::ST_LOG_MUL: state_nxt = unhs_pkg::ST_SC_RD;
      unhs_pkg::ST_SC_RD: begin
        if (j_r == J_END) state_nxt = unhs_pkg::ST_EMIT;
        else if (j_elig) state_nxt = unhs_pkg::ST_SC_DIVR;
      end
      unhs_pkg::ST_SC_DIVR:  state_nxt = unhs_pkg::ST_SC_WAITR;
      unhs_pkg::ST_SC_WAITR: if (div_done) state_nxt = unhs_pkg::ST_SC_WAITQ;
      unhs_pkg::ST_SC_WAITQ: if (sq_done) state_nxt = unhs_pkg::ST_SC_BONUS;
      unhs_pkg::ST_SC_BONUS: state_nxt = unhs_pkg::ST_SC_WAITM;
      unhs_pkg::ST_SC_WAITM: if (div_done) state_nxt = unhs_pkg::ST_SC_CMP;
      unhs_pkg::ST_SC_CMP:   state_nxt = unhs_pkg::ST_SC_RD;
      unhs_pkg::ST_EMIT:     if (emit_free) state_nxt = unhs_pkg::ST_IDLE;
      default:               state_nxt = unhs_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    mem_raddr = '0;
    div_start = 1'b0;
    div_dvd   = {mem_rdata_r.succ, 16'h0000};
    div_dvs   = mem_rdata_r.att;
    sq_start  = 1'b0;
    case (state_r)
      unhs_pkg::ST_CLEAR: mem_we = 1'b1;
      unhs_pkg::ST_IDLE:  q_pop = q_valid;
      unhs_pkg::ST_REC_RD, unhs_pkg::ST_QRY_RD: begin
        mem_raddr = arm_addr(cur_r.dest, cur_r.hop);
      end
      unhs_pkg::ST_REC_WR: begin
        mem_we         = 1'b1;
        mem_waddr      = arm_addr(cur_r.dest, cur_r.hop);
        mem_wdata.att  = sat_inc(mem_rdata_r.att);
        mem_wdata.succ = cur_r.success ? sat_inc(mem_rdata_r.succ) : mem_rdata_r.succ;
        mem_wdata.fail = cur_r.success ? mem_rdata_r.fail : sat_inc(mem_rdata_r.fail);
      end
      unhs_pkg::ST_QRY_DIV: div_start = mem_rdata_r.att != '0;
      unhs_pkg::ST_SEL_ARD, unhs_pkg::ST_SC_RD: begin
        mem_raddr = arm_addr(run_dest_r, j_hop);
      end
      unhs_pkg::ST_SC_DIVR: begin
        div_start = 1'b1;
        div_dvd   = unhs_pkg::DIVD_W'({lnv_r, 16'h0000});
      end
      unhs_pkg::ST_SC_WAITR: sq_start = div_done;
      unhs_pkg::ST_SC_BONUS: begin
        div_start = 1'b1;
        div_dvd   = {suc_r, 16'h0000};
        div_dvs   = att_r;
      end
      default: begin
      end
    endcase
  end

  assign clear_busy = state_r == unhs_pkg::ST_CLEAR;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // candidate payload store
  always_ff @(posedge clk) begin
    if (state_r == unhs_pkg::ST_IDLE && q_valid && q_cmd.op == unhs_pkg::OP_CAND &&
        cand_cnt_r != J_END) begin
      cand_hop_r[cand_cnt_r[unhs_pkg::CIDX_W-1:0]]  <= q_cmd.hop;
      cand_hlth_r[cand_cnt_r[unhs_pkg::CIDX_W-1:0]] <= q_cmd.healthy;
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      unhs_pkg::ST_IDLE: begin
        cur_r             <= q_cmd;
        res_r             <= '0;
        res_r.kind        <= (q_cmd.op == unhs_pkg::OP_QUERY) ? unhs_pkg::KIND_SNAPSHOT
                                                              : unhs_pkg::KIND_SELECT;
        res_r.chosen_hop  <= unhs_pkg::HOP_NONE;
        elig_r            <= '0;
        ne_r              <= '0;
        anyh_r            <= 1'b0;
        total_r           <= '0;
      end
      unhs_pkg::ST_QRY_DIV: begin
        res_r.chosen_hop  <= cur_r.hop;
        res_r.attempts    <= mem_rdata_r.att;
        res_r.successes   <= mem_rdata_r.succ;
        res_r.failures    <= mem_rdata_r.fail;
        res_r.mean_reward <= '0;
      end
      unhs_pkg::ST_QRY_WAIT: begin
        if (div_done) res_r.mean_reward <= div_q[unhs_pkg::MEAN_W-1:0];
      end
      unhs_pkg::ST_SEL_SCAN: begin
        if (!dest_bad && j_r != cand_cnt_r && scan_ok) begin
          elig_r[jx] <= 1'b1;
          ne_r       <= ne_r + 1'b1;
          anyh_r     <= anyh_r | cand_hlth_r[jx];
        end
      end
      unhs_pkg::ST_SEL_FILT: begin
        // keep only the healthy subset when one exists
        if (anyh_r) elig_r <= elig_r & cand_hlth_r;
      end
      unhs_pkg::ST_SEL_ARD: begin
        norm_r <= total_r;
        k_r    <= unhs_pkg::K_W'(unhs_pkg::TOT_W - 1);
      end
      unhs_pkg::ST_SEL_ACHK: begin
        total_r <= total_r + unhs_pkg::TOT_W'(mem_rdata_r.att);
        norm_r  <= total_r + unhs_pkg::TOT_W'(mem_rdata_r.att);
        if (mem_rdata_r.att == '0) res_r.chosen_hop <= j_hop;
      end
      unhs_pkg::ST_LOG_NORM: begin
        if (norm_r[unhs_pkg::TOT_W-1]) begin
          m_r    <= norm_r[unhs_pkg::TOT_W-1 -: 31];
          frac_r <= '0;
        end else begin
          norm_r <= {norm_r[unhs_pkg::TOT_W-2:0], 1'b0};
          k_r    <= k_r - 1'b1;
        end
      end
      unhs_pkg::ST_LOG_SQ: begin
        if (sq_val[31]) begin
          m_r    <= sq_val[31:1];
          frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          m_r    <= sq_val[30:0];
          frac_r <= {frac_r[14:0], 1'b0};
        end
      end
      unhs_pkg::ST_LOG_MUL: begin
        lnv_r        <= ln_prod[37:16];
        best_hop_r   <= unhs_pkg::HOP_NONE;
        best_score_r <= '0;
      end
      unhs_pkg::ST_SC_RD: begin
        if (j_r == J_END) res_r.chosen_hop <= best_hop_r;
      end
      unhs_pkg::ST_SC_DIVR: begin
        att_r <= mem_rdata_r.att;
        suc_r <= mem_rdata_r.succ;
      end
      unhs_pkg::ST_SC_WAITQ: begin
        if (sq_done) root_r <= sq_root;
      end
      unhs_pkg::ST_SC_BONUS: bonus_r <= bonus_prod[35:12];
      unhs_pkg::ST_SC_WAITM: begin
        if (div_done) mean_r <= div_q[unhs_pkg::MEAN_W-1:0];
      end
      unhs_pkg::ST_SC_CMP: begin
        if (better) begin
          best_hop_r   <= j_hop;
          best_score_r <= score;
        end
      end
      default: begin
      end
    endcase
    if (state_r == unhs_pkg::ST_EMIT && emit_free) begin
      out_data_r <= res_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= unhs_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      cand_cnt_r  <= '0;
      run_dest_r  <= '0;
      run_excl_r  <= '0;
      j_r         <= '0;
      sq_i_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == unhs_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;

      if (state_r == unhs_pkg::ST_EMIT && emit_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      case (state_r)
        unhs_pkg::ST_IDLE: begin
          j_r <= '0;
          if (q_valid && q_cmd.op == unhs_pkg::OP_CAND) begin
            if (cand_cnt_r == '0) begin
              run_dest_r <= q_cmd.dest;
              run_excl_r <= q_cmd.excl;
            end
            if (cand_cnt_r != J_END) cand_cnt_r <= cand_cnt_r + 1'b1;
          end
        end
        unhs_pkg::ST_SEL_SCAN: begin
          if (dest_bad || j_r == cand_cnt_r) begin
            cand_cnt_r <= '0;
            j_r        <= '0;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        unhs_pkg::ST_SEL_ARD: begin
          if (j_r != J_END && !j_elig) j_r <= j_r + 1'b1;
        end
        unhs_pkg::ST_SEL_ACHK: j_r <= j_r + 1'b1;
        unhs_pkg::ST_LOG_NORM: begin
          sq_i_r <= '0;
          j_r    <= '0;
        end
        unhs_pkg::ST_LOG_SQ: sq_i_r <= sq_i_r + 1'b1;
        unhs_pkg::ST_SC_RD: begin
          if (j_r != J_END && !j_elig) j_r <= j_r + 1'b1;
        end
        unhs_pkg::ST_SC_CMP: j_r <= j_r + 1'b1;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/ucb1_next_hop_selector.sv
// Top level of the UCB1 next hop selector: front end, command queue, engine, gain register.
`default_nettype none

// UCB1 next hop selector. Keeps saturating attempt, success and failure
// counters for every (destination, next hop) pair in an on-chip memory of
// NODES*NODES words. After reset a clearing pass writes zero to every word,
// one per cycle, and in_ready stays low until it ends; the gain register can
// be written during that time. The front end classifies items into a
// two-entry command queue, dropping outcome records with out-of-range ids
// and the unused function code at once, and keeps taking items while the
// engine works, until the queue fills. The engine handles one command at a
// time: an outcome record is a memory read, then a write back; a snapshot
// of a tried pair uses the shared 48-bit divider for its mean reward; a
// candidate without the last flag is only stored. At the end of a run the
// engine scans the stored candidates (one per cycle), reads the attempt
// count of each eligible one and returns at once if one was never tried.
// Otherwise it forms the natural log of the total attempt count through
// normalisation and 16 squaring steps, then scores each eligible candidate
// with two divisions and a square root; the highest score wins, the lower
// hop on a tie. Results leave through a register, so the next command can
// start while a result waits for out_ready.
module ucb1_next_hop_selector #(
  parameter int NODES = unhs_pkg::NODES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  unhs_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output unhs_pkg::out_item_t          out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [unhs_pkg::GAIN_W-1:0]   cfg_data
);

  // exploration gain c, unsigned Q4.12
  logic [unhs_pkg::GAIN_W-1:0] gain_r;

  logic           q_valid;
  logic           q_pop;
  unhs_pkg::cmd_t q_cmd;
  logic           clear_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= unhs_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= cfg_data;
    end
  end

  unhs_front #(
    .NODES (NODES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .clear_busy (clear_busy),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd)
  );

  unhs_back #(
    .NODES (NODES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .gain       (gain_r),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd),
    .clear_busy (clear_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/unhs_checker.sv
// Port-level checks of the UCB1 next hop selector and their binding.
`default_nettype none
`include "assert_macros.svh"

module unhs_checker #(
  parameter int NODES = unhs_pkg::NODES_DEF
) (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         out_valid,
  input wire                         out_ready,
  input unhs_pkg::out_item_t         out_data
);

  logic out_stall;
  logic out_sel;
  logic out_snap;
  logic snap_none;
  logic cnt_zero;
  logic bad_zero;
  logic snap_sane;
  logic hop_ok;

  assign out_stall = out_valid && !out_ready;
  assign out_sel   = out_valid && (out_data.kind == unhs_pkg::KIND_SELECT);
  assign out_snap  = out_valid && (out_data.kind == unhs_pkg::KIND_SNAPSHOT);
  assign snap_none = out_snap && (out_data.chosen_hop == unhs_pkg::HOP_NONE);
  assign cnt_zero  = (out_data.attempts == '0) && (out_data.successes == '0) &&
                     (out_data.failures == '0) && (out_data.mean_reward == '0);
  assign bad_zero  = (out_data.attempts == '0) && (out_data.mean_reward == '0);
  assign snap_sane = (out_data.successes <= out_data.attempts) &&
                     (out_data.mean_reward <= 17'h10000);
  assign hop_ok    = (out_data.chosen_hop == unhs_pkg::HOP_NONE) ||
                     (int'(out_data.chosen_hop) < NODES);

  `UNHS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data))

  `UNHS_ASSERT_IMPL(a_sel_no_counters, clk, rst_n, out_sel, cnt_zero)

  `UNHS_ASSERT_IMPL(a_bad_query_zero, clk, rst_n, snap_none, bad_zero)

  `UNHS_ASSERT_IMPL(a_snap_consistent, clk, rst_n, out_snap, snap_sane)

  `UNHS_ASSERT_IMPL(a_hop_range, clk, rst_n, out_valid, hop_ok)

endmodule

bind ucb1_next_hop_selector unhs_checker #(.NODES(NODES)) u_unhs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
